// ----- hdl/wld_pkg.sv -----
// Package for the worker load dispatcher: codes, sizes and sequencer types.
`timescale 1ns / 1ps
`default_nettype none
package wld_pkg;

  // Default sizes and register reset values
  localparam int WORKER_SLOTS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF    = 32;
  localparam int THREAD_LIMIT_DEF   = 23;
  localparam int QUEUE_LIMIT_DEF    = 27;
  localparam int WORKER_LIMIT_DEF   = 8;
  localparam int HOLDING_LIMIT_DEF  = 25;
  localparam int LOAD_TOP           = 255;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int ID_W     = 16;
  localparam int RKIND_W  = 2;
  localparam int SLOT_W   = 3;
  localparam int OKIND_W  = 3;
  localparam int LOAD_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_REQUEST  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RESPONSE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ONLINE   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd3;

  // Request kinds
  localparam logic [RKIND_W-1:0] RK_NORMAL   = 2'd0;
  localparam logic [RKIND_W-1:0] RK_URGENT   = 2'd1;
  localparam logic [RKIND_W-1:0] RK_DEFERRED = 2'd2;

  // Result kinds
  localparam logic [OKIND_W-1:0] RES_DISPATCH = 3'd0;
  localparam logic [OKIND_W-1:0] RES_SPAWN    = 3'd1;
  localparam logic [OKIND_W-1:0] RES_RETIRE   = 3'd2;
  localparam logic [OKIND_W-1:0] RES_READY    = 3'd3;
  localparam logic [OKIND_W-1:0] RES_DEFERRED = 3'd4;
  localparam logic [OKIND_W-1:0] RES_NONE     = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THREAD_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_LIMIT = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SPAWN,
    S_NORM,
    S_DEFER,
    S_RETIRE,
    S_RD,
    S_RDATA,
    S_DISP,
    S_READY,
    S_DONE
  } state_t;

  // What a dispatch step does after it fires
  typedef enum logic [2:0] {
    M_SINGLE,
    M_URGENT,
    M_BUDGET,
    M_FLUSH
  } mode_t;

endpackage
`default_nettype wire

// ----- hdl/wld_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/worker_load_dispatcher_unit.sv -----
// Worker load dispatcher top level: load table, holding queue and sequencer.
//
// Usage: one input request per item on in_* (action and request kind in
// in_tuser, request id and worker slot in in_tdata). Each item yields one or
// more results on out_* (result kind in out_tuser, tag and slot in
// out_tdata); out_tlast marks the final result of an item, and an item with
// nothing to report yields a single "none" result.
// Timing: every item first scans all worker slots, one slot per cycle.
// Draining the queue against a budget reads the first drained request
// through the RAM (read, data, dispatch); each further one rescans the
// slots first; a worker coming online flushes the queue, reading and
// dispatching one entry at a time.
// The next item is taken once the last result of the current one sits in the
// output register. The holding queue lives in a RAM with registered read data.
// Reset (rst_n low, synchronous): loads and presence clear, queue empties,
// one worker spawn is counted as outstanding, registers take their defaults.
// Stall: with out_tready low the sequencer holds, at most one result parked behind
// the output register; the user writes configuration only when idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none
module worker_load_dispatcher_unit #(
  parameter int WORKER_SLOTS = wld_pkg::WORKER_SLOTS_DEF,
  parameter int QUEUE_DEPTH  = wld_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request input
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,  // request_id, worker_slot, pad
  input  wire logic [3:0]                    in_tuser,  // action, request_kind
  // result output
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [23:0]                   out_tdata, // request_tag, target_slot, pad
  output logic      [2:0]                    out_tuser, // result_kind
  output logic                               out_tlast,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [wld_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [wld_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wld_pkg::*;

  localparam int SW   = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
  localparam int PW   = $clog2(WORKER_SLOTS + 1);
  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = LOAD_W + PW;

  // Configuration
  logic [7:0] thread_limit_r, queue_limit_r;
  logic [3:0] worker_limit_r;
  logic [4:0] holding_limit_r;

  // Architectural state
  logic [LOAD_W-1:0] load_r [WORKER_SLOTS];
  logic [LOAD_W-1:0] load_nxt [WORKER_SLOTS];
  logic [WORKER_SLOTS-1:0] present_r, present_nxt;
  logic [QW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic spawn_pend_r, spawn_pend_nxt;
  logic ready_sent_r, ready_sent_nxt;

  // Sequencer
  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic rescan_r, rescan_nxt;
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [RKIND_W-1:0]  kind_r, kind_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [ID_W-1:0]     tag_r, tag_nxt;
  logic [SUMW-1:0]     budget_r, budget_nxt;

  // Scan accumulators
  logic [SW-1:0]   sc_r, sc_nxt;
  logic [PW-1:0]   pcnt_r, pcnt_nxt;
  logic [SW-1:0]   lp_r, lp_nxt, tb_r, tb_nxt, mn_r, mn_nxt, zi_r, zi_nxt;
  logic            lp_v_r, lp_v_nxt, zi_v_r, zi_v_nxt;
  logic [SUMW-1:0] idle_r, idle_nxt, qsum_r, qsum_nxt;
  logic [LOAD_W-1:0] tb_best_r, tb_best_nxt;
  logic [LOAD_W:0]   mn_best_r, mn_best_nxt;

  // Result staging: one parked result behind the output register
  logic pend_v_r, pend_v_nxt;
  logic [OKIND_W-1:0] pend_kind_r, pend_kind_nxt;
  logic [ID_W-1:0]    pend_tag_r, pend_tag_nxt;
  logic [SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic out_v_r;
  logic [OKIND_W-1:0] out_kind_r;
  logic [ID_W-1:0]    out_tag_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic out_last_r;

  // Queue RAM
  logic           q_we;
  logic [QW-1:0]  q_waddr;
  logic [ID_W-1:0] q_wdata, q_rdata;

  logic out_free, emit_ok, emit_c, finish_c;
  logic [OKIND_W-1:0] emit_kind;
  logic [ID_W-1:0]    emit_tag;
  logic [SLOT_W-1:0]  emit_slot;

  logic [SW-1:0] best_c, slot_idx, tgt_c;
  logic slot_ok;
  logic [LOAD_W-1:0] sc_load;
  logic sc_pres;
  logic [31:0] tail_sum;
  logic q_full;
  logic [CW-1:0] cnt_after;
  logic [SUMW-1:0] budget_sel;

  wld_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(head_r),
    .rdata(q_rdata)
  );

  // Handshake helpers
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_v_r || out_tready;
  assign emit_ok   = !pend_v_r || out_free;

  // Best slot from the last scan
  assign best_c   = (idle_r != '0) ? ((tb_best_r != '0) ? tb_r : lp_r) : mn_r;
  assign slot_idx = SW'(slot_r);
  assign slot_ok  = (32'(slot_r) < WORKER_SLOTS);
  assign sc_load  = load_r[sc_r];
  assign sc_pres  = present_r[sc_r];

  // Queue tail address and fill
  assign tail_sum  = (32'(head_r) + 32'(count_r) >= QUEUE_DEPTH) ?
                     (32'(head_r) + 32'(count_r) - QUEUE_DEPTH) :
                     (32'(head_r) + 32'(count_r));
  assign q_waddr   = QW'(tail_sum);
  assign q_full    = (32'(count_r) >= QUEUE_DEPTH);
  assign cnt_after = q_full ? count_r : count_r + CW'(1);

  always_comb begin
    case (mode_r)
      M_FLUSH:  tgt_c = slot_idx;
      M_URGENT: tgt_c = lp_r;
      default:  tgt_c = best_c;
    endcase
  end

  assign budget_sel = (idle_r != '0) ? idle_r : qsum_r;

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    rescan_nxt     = rescan_r;
    act_nxt        = act_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    slot_nxt       = slot_r;
    tag_nxt        = tag_r;
    budget_nxt     = budget_r;
    load_nxt       = load_r;
    present_nxt    = present_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    spawn_pend_nxt = spawn_pend_r;
    ready_sent_nxt = ready_sent_r;
    sc_nxt         = sc_r;
    pcnt_nxt       = pcnt_r;
    lp_nxt         = lp_r;
    lp_v_nxt       = lp_v_r;
    tb_nxt         = tb_r;
    tb_best_nxt    = tb_best_r;
    mn_nxt         = mn_r;
    mn_best_nxt    = mn_best_r;
    zi_nxt         = zi_r;
    zi_v_nxt       = zi_v_r;
    idle_nxt       = idle_r;
    qsum_nxt       = qsum_r;
    q_we           = 1'b0;
    q_wdata        = id_r;
    emit_c         = 1'b0;
    emit_kind      = RES_NONE;
    emit_tag       = '0;
    emit_slot      = '0;
    finish_c       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = in_tuser[1:0];
          kind_nxt   = in_tuser[3:2];
          id_nxt     = in_tdata[15:0];
          slot_nxt   = in_tdata[18:16];
          rescan_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
        sc_nxt      = '0;
        pcnt_nxt    = '0;
        lp_v_nxt    = 1'b0;
        zi_v_nxt    = 1'b0;
        idle_nxt    = '0;
        qsum_nxt    = '0;
        tb_nxt      = '0;
        tb_best_nxt = '0;
        mn_nxt      = '0;
        mn_best_nxt = (LOAD_W+1)'(LOAD_TOP + 1);
      end

      // One slot per cycle: count, sums and candidate picks
      S_SCAN: begin
        if (sc_pres) begin
          pcnt_nxt = pcnt_r + PW'(1);
          if (!lp_v_r) begin
            lp_nxt   = sc_r;
            lp_v_nxt = 1'b1;
          end
          if (sc_load < thread_limit_r) begin
            idle_nxt = idle_r + SUMW'(thread_limit_r - sc_load);
            if (tb_best_r < sc_load) begin
              tb_nxt      = sc_r;
              tb_best_nxt = sc_load;
            end
          end
          if (sc_load < queue_limit_r) begin
            qsum_nxt = qsum_r + SUMW'(queue_limit_r - sc_load);
          end
          if ({1'b0, sc_load} < mn_best_r) begin
            mn_nxt      = sc_r;
            mn_best_nxt = {1'b0, sc_load};
          end
          if (sc_load == '0 && !zi_v_r) begin
            zi_nxt   = sc_r;
            zi_v_nxt = 1'b1;
          end
        end
        sc_nxt = sc_r + SW'(1);
        if (sc_r == SW'(WORKER_SLOTS - 1)) begin
          sc_nxt    = '0;
          state_nxt = rescan_r ? S_RD : S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_DONE;
        unique case (act_r)
          ACT_REQUEST: begin
            if (kind_r == RK_URGENT) begin
              if (lp_v_r) begin
                tag_nxt   = id_r;
                mode_nxt  = M_URGENT;
                state_nxt = S_DISP;
              end else if (!q_full) begin
                q_we      = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end else if (kind_r == RK_DEFERRED) begin
              state_nxt = S_DEFER;
            end else if (pcnt_r == '0) begin
              if (!spawn_pend_r) begin
                state_nxt = S_SPAWN;
              end else if (!q_full) begin
                q_we      = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end else if (32'(pcnt_r) >= 32'(worker_limit_r)) begin
              tag_nxt   = id_r;
              mode_nxt  = M_SINGLE;
              state_nxt = S_DISP;
            end else begin
              budget_nxt = budget_sel;
              state_nxt  = (idle_r == '0 && !spawn_pend_r) ? S_SPAWN : S_NORM;
            end
          end
          ACT_RESPONSE: begin
            if (slot_ok && present_r[slot_idx] && load_r[slot_idx] != '0) begin
              load_nxt[slot_idx] = load_r[slot_idx] - LOAD_W'(1);
            end
          end
          ACT_ONLINE: begin
            if (slot_ok) begin
              spawn_pend_nxt        = 1'b0;
              present_nxt[slot_idx] = 1'b1;
              load_nxt[slot_idx]    = '0;
              mode_nxt              = M_FLUSH;
              state_nxt             = (count_r != '0) ? S_RD : S_READY;
            end
          end
          ACT_TICK: begin
            if (pcnt_r > PW'(1) && zi_v_r) begin
              state_nxt = S_RETIRE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // Spawn request; with no worker present the request then waits in the queue
      S_SPAWN: begin
        if (emit_ok) begin
          emit_c         = 1'b1;
          emit_kind      = RES_SPAWN;
          spawn_pend_nxt = 1'b1;
          if (pcnt_r == '0) begin
            if (!q_full) begin
              q_we      = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_NORM;
          end
        end
      end

      // Normal request with a known budget
      S_NORM: begin
        if (budget_r != '0) begin
          if (count_r != '0) begin
            if (!q_full) begin
              q_we      = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            mode_nxt  = M_BUDGET;
            state_nxt = S_RD;
          end else begin
            tag_nxt   = id_r;
            mode_nxt  = M_SINGLE;
            state_nxt = S_DISP;
          end
        end else begin
          if (!q_full) begin
            q_we      = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          mode_nxt  = M_SINGLE;
          state_nxt = (32'(cnt_after) > 32'(holding_limit_r)) ? S_RD : S_DONE;
        end
      end

      S_DEFER: begin
        if (emit_ok) begin
          emit_c    = 1'b1;
          emit_kind = RES_DEFERRED;
          emit_tag  = id_r;
          state_nxt = S_DONE;
        end
      end

      S_RETIRE: begin
        if (emit_ok) begin
          emit_c            = 1'b1;
          emit_kind         = RES_RETIRE;
          emit_slot         = SLOT_W'(zi_r);
          present_nxt[zi_r] = 1'b0;
          state_nxt         = S_DONE;
        end
      end

      // Queue head read in flight
      S_RD: state_nxt = S_RDATA;

      S_RDATA: begin
        tag_nxt   = q_rdata;
        head_nxt  = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
        count_nxt = count_r - CW'(1);
        state_nxt = S_DISP;
      end

      // Dispatch one tag and raise the target's load
      S_DISP: begin
        if (emit_ok) begin
          emit_c    = 1'b1;
          emit_kind = RES_DISPATCH;
          emit_tag  = tag_r;
          emit_slot = SLOT_W'(tgt_c);
          if (load_r[tgt_c] != LOAD_W'(LOAD_TOP)) begin
            load_nxt[tgt_c] = load_r[tgt_c] + LOAD_W'(1);
          end
          state_nxt = S_DONE;
          if (mode_r == M_FLUSH) begin
            state_nxt = (count_r != '0) ? S_RD : S_READY;
          end else if (mode_r == M_BUDGET) begin
            budget_nxt = budget_r - SUMW'(1);
            if (budget_r != SUMW'(1) && count_r != '0) begin
              rescan_nxt  = 1'b1;
              sc_nxt      = '0;
              pcnt_nxt    = '0;
              lp_v_nxt    = 1'b0;
              zi_v_nxt    = 1'b0;
              idle_nxt    = '0;
              qsum_nxt    = '0;
              tb_nxt      = '0;
              tb_best_nxt = '0;
              mn_nxt      = '0;
              mn_best_nxt = (LOAD_W+1)'(LOAD_TOP + 1);
              state_nxt   = S_SCAN;
            end
          end
        end
      end

      S_READY: begin
        if (!ready_sent_r) begin
          if (emit_ok) begin
            emit_c         = 1'b1;
            emit_kind      = RES_READY;
            ready_sent_nxt = 1'b1;
            state_nxt      = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Release the parked result, or a none result, as the last one
      S_DONE: begin
        if (out_free) begin
          finish_c  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result staging next values
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_tag_nxt  = pend_tag_r;
    pend_slot_nxt = pend_slot_r;
    if (emit_c) begin
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = emit_kind;
      pend_tag_nxt  = emit_tag;
      pend_slot_nxt = emit_slot;
    end else if (finish_c) begin
      pend_v_nxt = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if ((emit_c && pend_v_r) || finish_c) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (emit_c && pend_v_r) begin
      out_kind_r <= pend_kind_r;
      out_tag_r  <= pend_tag_r;
      out_slot_r <= pend_slot_r;
      out_last_r <= 1'b0;
    end else if (finish_c) begin
      out_kind_r <= pend_v_r ? pend_kind_r : RES_NONE;
      out_tag_r  <= pend_v_r ? pend_tag_r : '0;
      out_slot_r <= pend_v_r ? pend_slot_r : '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'b0, out_slot_r, out_tag_r};
  assign out_tlast  = out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thread_limit_r  <= 8'(THREAD_LIMIT_DEF);
      queue_limit_r   <= 8'(QUEUE_LIMIT_DEF);
      worker_limit_r  <= 4'(WORKER_LIMIT_DEF);
      holding_limit_r <= 5'(HOLDING_LIMIT_DEF);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_THREAD_LIMIT:  thread_limit_r  <= cfg_wdata;
        CFG_QUEUE_LIMIT:   queue_limit_r   <= cfg_wdata;
        CFG_WORKER_LIMIT:  worker_limit_r  <= cfg_wdata[3:0];
        CFG_HOLDING_LIMIT: holding_limit_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= M_SINGLE;
      rescan_r     <= 1'b0;
      present_r    <= '0;
      head_r       <= '0;
      count_r      <= '0;
      spawn_pend_r <= 1'b1;
      ready_sent_r <= 1'b0;
      pend_v_r     <= 1'b0;
      for (int i = 0; i < WORKER_SLOTS; i++) begin
        load_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      rescan_r     <= rescan_nxt;
      present_r    <= present_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      spawn_pend_r <= spawn_pend_nxt;
      ready_sent_r <= ready_sent_nxt;
      pend_v_r     <= pend_v_nxt;
      load_r       <= load_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    slot_r      <= slot_nxt;
    tag_r       <= tag_nxt;
    budget_r    <= budget_nxt;
    sc_r        <= sc_nxt;
    pcnt_r      <= pcnt_nxt;
    lp_r        <= lp_nxt;
    lp_v_r      <= lp_v_nxt;
    tb_r        <= tb_nxt;
    tb_best_r   <= tb_best_nxt;
    mn_r        <= mn_nxt;
    mn_best_r   <= mn_best_nxt;
    zi_r        <= zi_nxt;
    zi_v_r      <= zi_v_nxt;
    idle_r      <= idle_nxt;
    qsum_r      <= qsum_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_tag_r  <= pend_tag_nxt;
    pend_slot_r <= pend_slot_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= QUEUE_DEPTH)
    else $error("holding queue count above depth");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("result parked while idle");
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_SCAN && !rescan_r)
    else $error("accepted request did not start a scan");
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    finish_c |=> out_tvalid && out_tlast && state_r == S_IDLE)
    else $error("item end without a last result");
`endif

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the worker load dispatcher: queued driver, monitor and predictor.
`timescale 1ns / 1ps
module testbench;
  import wld_pkg::*;

  localparam int NSLOT = 8;
  localparam int QDEP = 32;
  localparam int MAX_RES = 34;
  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 600;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0] id;
    logic [RKIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
  } request_t;

  typedef struct packed {
    logic [OKIND_W-1:0] kind;
    logic [ID_W-1:0] tag;
    logic [SLOT_W-1:0] slot;
    logic last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  worker_load_dispatcher_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state
  logic [7:0] load_tbl[NSLOT];
  bit present[NSLOT];
  logic [15:0] hold_q[QDEP];
  int q_head, q_count;
  bit spawn_pend, ready_done;
  int lim_thread, lim_queue, lim_worker, lim_hold;
  int n_res;

  request_t pending[$];
  outcome_t expected[$];
  int errors = 0;

  task automatic post(logic [2:0] k, logic [15:0] t, logic [2:0] s);
    outcome_t o;
    if (n_res >= MAX_RES) return;
    o.kind = k; o.tag = t; o.slot = s; o.last = 1'b0;
    expected.push_back(o);
    n_res++;
  endtask

  task automatic bump(int s);
    if (load_tbl[s] != 8'hFF) load_tbl[s] = load_tbl[s] + 8'd1;
  endtask

  task automatic hold_push(logic [15:0] id);
    if (q_count >= QDEP) return;
    hold_q[(q_head + q_count) % QDEP] = id;
    q_count++;
  endtask

  function automatic logic [15:0] hold_pop();
    logic [15:0] v;
    v = hold_q[q_head];
    q_head = (q_head + 1) % QDEP;
    q_count--;
    return v;
  endfunction

  function automatic int n_present();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (present[i]) n++;
    return n;
  endfunction

  function automatic int first_present();
    for (int i = 0; i < NSLOT; i++) if (present[i]) return i;
    return -1;
  endfunction

  function automatic int spare(int lim);
    int sum;
    sum = 0;
    for (int i = 0; i < NSLOT; i++)
      if (present[i] && load_tbl[i] < lim) sum += lim - load_tbl[i];
    return sum;
  endfunction

  // Busiest slot under the thread limit, else least loaded; lowest index wins ties
  function automatic int pick_slot();
    int pick, best;
    pick = first_present();
    if (spare(lim_thread) > 0) begin
      best = 0;
      for (int i = 0; i < NSLOT; i++)
        if (present[i] && load_tbl[i] < lim_thread && best < load_tbl[i]) begin
          pick = i; best = load_tbl[i];
        end
    end else begin
      best = 256;
      for (int i = 0; i < NSLOT; i++)
        if (present[i] && load_tbl[i] < best) begin
          pick = i; best = load_tbl[i];
        end
    end
    return pick;
  endfunction

  task automatic send_best(logic [15:0] id);
    int s;
    s = pick_slot();
    bump(s);
    post(RES_DISPATCH, id, s[2:0]);
  endtask

  task automatic want_spawn();
    if (!spawn_pend) begin
      spawn_pend = 1'b1;
      post(RES_SPAWN, '0, '0);
    end
  endtask

  task automatic route_normal(logic [15:0] id);
    int budget, idle;
    if (n_present() == 0) begin
      want_spawn();
      hold_push(id);
      return;
    end
    if (n_present() >= lim_worker) begin
      send_best(id);
      return;
    end
    idle = spare(lim_thread);
    if (idle > 0) budget = idle;
    else begin
      want_spawn();
      budget = spare(lim_queue);
    end
    if (budget > 0) begin
      if (q_count > 0) begin
        hold_push(id);
        while (budget > 0 && q_count > 0) begin
          send_best(hold_pop());
          budget--;
        end
      end else send_best(id);
    end else begin
      hold_push(id);
      if (q_count > lim_hold) send_best(hold_pop());
    end
  endtask

  task automatic predict(request_t r);
    int lp;
    n_res = 0;
    case (r.action)
      ACT_REQUEST: begin
        if (r.kind == RK_URGENT) begin
          lp = first_present();
          if (lp < 0) hold_push(r.id);
          else begin
            bump(lp);
            post(RES_DISPATCH, r.id, lp[2:0]);
          end
        end else if (r.kind == RK_DEFERRED) post(RES_DEFERRED, r.id, '0);
        else route_normal(r.id);
      end
      ACT_RESPONSE: begin
        if (present[r.slot] && load_tbl[r.slot] != 0) load_tbl[r.slot] = load_tbl[r.slot] - 8'd1;
      end
      ACT_ONLINE: begin
        spawn_pend = 1'b0;
        present[r.slot] = 1'b1;
        load_tbl[r.slot] = '0;
        while (q_count > 0) begin
          lp = hold_pop();
          bump(r.slot);
          post(RES_DISPATCH, lp[15:0], r.slot);
        end
        if (!ready_done) begin
          ready_done = 1'b1;
          post(RES_READY, '0, '0);
        end
      end
      default: begin
        if (n_present() > 1) begin
          for (int i = 0; i < NSLOT; i++)
            if (present[i] && load_tbl[i] == 0) begin
              present[i] = 1'b0;
              post(RES_RETIRE, '0, i[2:0]);
              break;
            end
        end
      end
    endcase
    if (n_res == 0) post(RES_NONE, '0, '0);
    expected[$].last = 1'b1;
  endtask

  // Driver: bursts of requests separated by random gaps
  request_t cur;
  int burst_left = 0;
  int gap_left = 0;
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict(cur);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_tdata <= {5'd0, cur.slot, cur.id};
          in_tuser <= {cur.kind, cur.action};
          in_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern: random free-running and choppy stretches
  int stall_mode = 0;
  int mode_cnt = 0;

  always @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected.size() == 0) begin
          $error("result with nothing expected: kind %0d", out_tuser);
          errors++;
        end else begin
          e = expected.pop_front();
          if (out_tuser !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, out_tuser); errors++;
          end
          if (out_tdata[15:0] !== e.tag) begin
            $error("request_tag exp %0h got %0h", e.tag, out_tdata[15:0]); errors++;
          end
          if (out_tdata[18:16] !== e.slot) begin
            $error("target_slot exp %0d got %0d", e.slot, out_tdata[18:16]); errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_tlast); errors++;
          end
        end
      end
      if (mode_cnt == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_cnt = $urandom_range(20, 120);
      end else mode_cnt--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 7) < 3);
      endcase
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic request_t mk(logic [1:0] a, logic [15:0] id, logic [1:0] k, logic [2:0] s);
    request_t r;
    r.action = a; r.id = id; r.kind = k; r.slot = s;
    return r;
  endfunction

  // Mostly requests, with enough control events to move workers in and out
  function automatic request_t rand_req();
    int p;
    int w;
    p = $urandom_range(0, 99);
    w = $urandom_range(0, 99);
    if (p < 58) begin
      return mk(ACT_REQUEST, 16'($urandom_range(0, 65535)),
                (w < 60) ? RK_NORMAL : (w < 75) ? RK_URGENT : (w < 90) ? RK_DEFERRED : 2'd3,
                3'($urandom_range(0, 7)));
    end else if (p < 76) return mk(ACT_RESPONSE, 16'($urandom_range(0, 65535)),
                                   2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    else if (p < 88) return mk(ACT_ONLINE, 16'($urandom_range(0, 65535)),
                               2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    else return mk(ACT_TICK, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                   3'($urandom_range(0, 7)));
  endfunction

  task automatic settle();
    while (pending.size() > 0 || in_tvalid || expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THREAD_LIMIT: lim_thread = val;
      CFG_QUEUE_LIMIT: lim_queue = val;
      CFG_WORKER_LIMIT: lim_worker = val;
      default: lim_hold = val;
    endcase
  endtask

  task automatic set_limits(int t, int q, int w, int h);
    settle();
    write_reg(CFG_THREAD_LIMIT, t);
    write_reg(CFG_QUEUE_LIMIT, q);
    write_reg(CFG_WORKER_LIMIT, w);
    write_reg(CFG_HOLDING_LIMIT, h);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) pending.push_back(rand_req());
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      load_tbl[i] = '0;
      present[i] = 1'b0;
    end
    q_head = 0; q_count = 0;
    spawn_pend = 1'b1; ready_done = 1'b0;
    lim_thread = THREAD_LIMIT_DEF; lim_queue = QUEUE_LIMIT_DEF;
    lim_worker = WORKER_LIMIT_DEF; lim_hold = HOLDING_LIMIT_DEF;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no worker, deferred, odd kind, unknown slot, idle tick, onlines, retire
    pending.push_back(mk(ACT_REQUEST, 16'h0000, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_REQUEST, 16'hFFFF, RK_URGENT, 3'd7));
    pending.push_back(mk(ACT_REQUEST, 16'h1234, RK_DEFERRED, 3'd0));
    pending.push_back(mk(ACT_REQUEST, 16'hABCD, 2'd3, 3'd5));
    pending.push_back(mk(ACT_RESPONSE, 16'h0, RK_NORMAL, 3'd7));
    pending.push_back(mk(ACT_TICK, 16'h0, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_ONLINE, 16'h0, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_TICK, 16'h0, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_REQUEST, 16'h5555, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_ONLINE, 16'h0, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_ONLINE, 16'hFFFF, 2'd3, 3'd7));
    pending.push_back(mk(ACT_REQUEST, 16'hAAAA, RK_URGENT, 3'd0));
    pending.push_back(mk(ACT_RESPONSE, 16'h0, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_RESPONSE, 16'h0, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_TICK, 16'h0, RK_NORMAL, 3'd0));
    pending.push_back(mk(ACT_TICK, 16'h0, RK_NORMAL, 3'd0));
    add_random(25);

    // Tight limits: one worker allowed, short holding queue
    set_limits(1, 1, 1, 1);
    add_random(20);

    // Wide limits: deep queues, full holding queue overflow
    set_limits(255, 255, 8, 31);
    pending.push_back(mk(ACT_TICK, 16'h0, RK_NORMAL, 3'd0));
    for (int i = 0; i < 34; i++)
      pending.push_back(mk(ACT_REQUEST, 16'($urandom_range(0, 65535)), RK_NORMAL, 3'd0));

    // Load saturation on the lowest present slot
    set_limits(2, 3, 2, 5);
    pending.push_back(mk(ACT_ONLINE, 16'h0, RK_NORMAL, 3'd0));
    for (int i = 0; i < 258; i++)
      pending.push_back(mk(ACT_REQUEST, 16'($urandom_range(0, 65535)), RK_URGENT, 3'd0));
    add_random(20);

    // Random settings
    for (int ph = 0; ph < 3; ph++) begin
      set_limits($urandom_range(1, 40), $urandom_range(1, 50), $urandom_range(1, 8),
                 $urandom_range(1, 31));
      add_random(15);
    end

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
